### rtl/atss_pkg.sv
// Shared types and constants of the altitude-triggered sample sequencer.
`default_nettype none

package atss_pkg;

  // Field widths fixed by the register map and the request formats.
  localparam int unsigned ALT_W     = 17;
  localparam int unsigned TICK_W    = 24;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned MASK_W    = 6;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 24;

  // Register map: altitude registers first, then the two shared lengths.
  localparam int unsigned NUM_ALT_REGS = 6;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAN_TICKS  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_TICKS = 4'd7;

  // Reset values of the configuration registers.
  localparam int unsigned ALT_STEP_M    = 1000;
  localparam int unsigned CLEAN_RESET   = 5000;
  localparam int unsigned SAMPLE_RESET  = 10000;

  // Channel phase codes.
  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE   = 3'd0,
    PH_CLEAN  = 3'd1,
    PH_SEAL   = 3'd2,
    PH_ACTIVE = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  // What one channel does on the current tick.
  typedef struct packed {
    logic   pump_wr;
    logic   pump_val;
    logic   exh_wr;
    logic   exh_val;
    logic   sol;
    phase_e phase;
  } atss_chan_evt_t;

endpackage

`default_nettype wire

### rtl/atss_if.sv
// Handshake interfaces for the tick, result and configuration channels.
`default_nettype none

interface atss_in_if;
  logic                    valid;
  logic                    ready;
  logic signed [16:0]      altitude;

  modport source (output valid, output altitude, input ready);
  modport sink   (input valid, input altitude, output ready);
endinterface

interface atss_out_if;
  logic       valid;
  logic       ready;
  logic       pump_on;
  logic       exhaust_open;
  logic [5:0] solenoid_mask;
  logic [2:0] reported_phase;

  modport source (output valid, output pump_on, output exhaust_open,
                  output solenoid_mask, output reported_phase, input ready);
  modport sink   (input valid, input pump_on, input exhaust_open,
                  input solenoid_mask, input reported_phase, output ready);
endinterface

interface atss_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [23:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/altitude_triggered_sample_sequencer_core.sv
// Top level of the altitude-triggered sample sequencer.
// An accepted tick request is held in the input register and passed to the result
// register when the result slot is free or is being emptied.
// Throughput: one tick per cycle while the output takes results; the input register
// and the result register form a two-stage pipe, so a tick is taken while a result
// waits downstream. The rate is set by the combinational channel update feeding the
// result register. Reset: all channels not started, pump, exhaust and solenoids off,
// registers at their default values; requests are taken straight out of reset.
`default_nettype none

module altitude_triggered_sample_sequencer_core #(
  parameter int unsigned NUM_CHANNELS = 6,
  parameter int unsigned SEAL_TICKS   = 500,
  parameter int unsigned TIMER_BITS   = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  atss_in_if.sink    in_i,
  atss_out_if.source out_o,
  atss_cfg_if.sink   cfg_i
);
  import atss_pkg::*;

  logic signed [ALT_W-1:0]  alt_reg [NUM_ALT_REGS];
  logic        [TICK_W-1:0] clean_ticks;
  logic        [TICK_W-1:0] sample_ticks;

  logic                     s1_valid_q;
  logic signed [ALT_W-1:0]  alt_q;
  logic                     out_valid_q;
  logic                     adv;

  atss_chan_evt_t           evt [NUM_CHANNELS];

  logic                     pump_q, pump_d;
  logic                     exh_q, exh_d;
  logic [MASK_W-1:0]        mask_q, mask_d;
  logic [PHASE_W-1:0]       rep_q, rep_d;

  // Configuration registers.
  atss_cfg_regs u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_i),
    .alt_o          (alt_reg),
    .clean_ticks_o  (clean_ticks),
    .sample_ticks_o (sample_ticks)
  );

  // Pipe control: the input stage moves on when the result slot is free.
  assign adv        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      alt_q <= in_i.altitude;
    end
  end

  // Channel machines; channels beyond the register map use fixed altitudes.
  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
    logic signed [ALT_W-1:0] thresh;
    if (c < NUM_ALT_REGS) begin : g_reg
      assign thresh = alt_reg[c];
    end else begin : g_fixed
      assign thresh = ALT_W'(ALT_STEP_M * (c + 1));
    end
    atss_channel #(
      .TIMER_BITS (TIMER_BITS),
      .SEAL_TICKS (SEAL_TICKS)
    ) u_chan (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .adv_i          (adv),
      .alt_i          (alt_q),
      .thresh_i       (thresh),
      .clean_ticks_i  (clean_ticks),
      .sample_ticks_i (sample_ticks),
      .evt_o          (evt[c])
    );
  end

  // Solenoid mask from the channels that have a bit in the result.
  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < NUM_CHANNELS) begin : g_on
      assign mask_d[b] = evt[b].sol;
    end else begin : g_off
      assign mask_d[b] = 1'b0;
    end
  end

  // Shared levels: the highest-numbered channel that drives a level wins.
  always_comb begin
    pump_d = pump_q;
    exh_d  = exh_q;
    rep_d  = PHASE_W'(PH_DONE);
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (evt[i].pump_wr) begin
        pump_d = evt[i].pump_val;
      end
      if (evt[i].exh_wr) begin
        exh_d = evt[i].exh_val;
      end
      if ((evt[i].phase == PH_CLEAN) || (evt[i].phase == PH_SEAL) ||
          (evt[i].phase == PH_ACTIVE)) begin
        rep_d = PHASE_W'(evt[i].phase);
      end
    end
  end

  // Result register; the pump and exhaust bits double as the shared levels.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pump_q      <= 1'b0;
      exh_q       <= 1'b0;
      mask_q      <= '0;
      rep_q       <= PHASE_W'(PH_DONE);
    end else begin
      if (adv) begin
        out_valid_q <= 1'b1;
        pump_q      <= pump_d;
        exh_q       <= exh_d;
        mask_q      <= mask_d;
        rep_q       <= rep_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.pump_on        = pump_q;
  assign out_o.exhaust_open   = exh_q;
  assign out_o.solenoid_mask  = mask_q;
  assign out_o.reported_phase = rep_q;

  // A held tick always reaches the result slot when that slot is empty.
  a_adv_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("tick not passed to empty result slot");

  // Input backpressure only when both stages are full and the output stalls.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid_q && out_valid_q && !out_o.ready))
    else $error("input stalled without cause");

  // A reported phase is always one of clean, seal, active or complete.
  a_rep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.reported_phase == PHASE_W'(PH_CLEAN)) ||
                     (out_o.reported_phase == PHASE_W'(PH_SEAL)) ||
                     (out_o.reported_phase == PHASE_W'(PH_ACTIVE)) ||
                     (out_o.reported_phase == PHASE_W'(PH_DONE))))
    else $error("reported phase out of range");

endmodule

`default_nettype wire

### rtl/atss_cfg_regs.sv
// Configuration register file: start altitudes and shared phase lengths.
`default_nettype none

module atss_cfg_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  atss_cfg_if.sink                              cfg_i,
  output logic signed [atss_pkg::ALT_W-1:0]     alt_o [atss_pkg::NUM_ALT_REGS],
  output logic        [atss_pkg::TICK_W-1:0]    clean_ticks_o,
  output logic        [atss_pkg::TICK_W-1:0]    sample_ticks_o
);
  import atss_pkg::*;

  localparam int unsigned AltIdxW = $clog2(NUM_ALT_REGS);

  logic signed [ALT_W-1:0]  alt_q [NUM_ALT_REGS];
  logic        [TICK_W-1:0] clean_q;
  logic        [TICK_W-1:0] sample_q;
  logic                     wr;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ALT_REGS; i++) begin
        alt_q[i] <= ALT_W'(ALT_STEP_M * (i + 1));
      end
      clean_q  <= TICK_W'(CLEAN_RESET);
      sample_q <= TICK_W'(SAMPLE_RESET);
    end else if (wr) begin
      if (cfg_i.index < CFG_IDX_W'(NUM_ALT_REGS)) begin
        alt_q[cfg_i.index[AltIdxW-1:0]] <= $signed(cfg_i.data[ALT_W-1:0]);
      end else if (cfg_i.index == REG_CLEAN_TICKS) begin
        clean_q <= cfg_i.data[TICK_W-1:0];
      end else if (cfg_i.index == REG_SAMPLE_TICKS) begin
        sample_q <= cfg_i.data[TICK_W-1:0];
      end
    end
  end

  assign alt_o          = alt_q;
  assign clean_ticks_o  = clean_q;
  assign sample_ticks_o = sample_q;

endmodule

`default_nettype wire

### rtl/atss_channel.sv
// One sample channel: phase, tick timer and solenoid level.
`default_nettype none

module atss_channel #(
  parameter int unsigned TIMER_BITS = 24,
  parameter int unsigned SEAL_TICKS = 500
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic signed [atss_pkg::ALT_W-1:0]   alt_i,
  input  logic signed [atss_pkg::ALT_W-1:0]   thresh_i,
  input  logic        [atss_pkg::TICK_W-1:0]  clean_ticks_i,
  input  logic        [atss_pkg::TICK_W-1:0]  sample_ticks_i,
  output atss_pkg::atss_chan_evt_t            evt_o
);
  import atss_pkg::*;

  phase_e                phase_q, phase_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d, timer_inc;
  logic                  sol_q, sol_d;
  logic                  running;
  logic                  served;
  logic [31:0]           t_ext;

  // Timer counts first in every running phase and saturates at all ones.
  assign running   = (phase_q == PH_CLEAN) || (phase_q == PH_SEAL) ||
                     (phase_q == PH_ACTIVE);
  assign timer_inc = (running && (timer_q != '1)) ? timer_q + TIMER_BITS'(1) : timer_q;
  assign t_ext     = 32'(timer_inc);
  assign served    = (thresh_i < alt_i) && (phase_q != PH_DONE);

  // Phase step for this tick.
  always_comb begin
    phase_d        = phase_q;
    timer_d        = timer_inc;
    sol_d          = sol_q;
    evt_o.pump_wr  = 1'b0;
    evt_o.pump_val = 1'b0;
    evt_o.exh_wr   = 1'b0;
    evt_o.exh_val  = 1'b0;
    if (served) begin
      unique case (phase_q)
        PH_CLEAN: begin
          if (t_ext >= 32'(clean_ticks_i)) begin
            evt_o.exh_wr = 1'b1;
            timer_d      = '0;
            phase_d      = PH_SEAL;
          end
        end
        PH_SEAL: begin
          if (t_ext >= 32'(SEAL_TICKS)) begin
            sol_d   = 1'b1;
            timer_d = '0;
            phase_d = PH_ACTIVE;
          end
        end
        PH_ACTIVE: begin
          if (t_ext >= 32'(sample_ticks_i)) begin
            sol_d         = 1'b0;
            evt_o.pump_wr = 1'b1;
            phase_d       = PH_DONE;
          end
        end
        default: begin
          // Not started, or any code that means nothing: start cleaning.
          evt_o.pump_wr  = 1'b1;
          evt_o.pump_val = 1'b1;
          evt_o.exh_wr   = 1'b1;
          evt_o.exh_val  = 1'b1;
          timer_d        = '0;
          phase_d        = PH_CLEAN;
        end
      endcase
    end
    evt_o.sol   = sol_d;
    evt_o.phase = phase_d;
  end

  // State moves only when the tick is passed to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= '0;
      sol_q   <= 1'b0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      sol_q   <= sol_d;
    end
  end

endmodule

`default_nettype wire

### tb/altitude_triggered_sample_sequencer_core_tb.sv
// Self-checking testbench of the altitude-triggered sample sequencer core.
module altitude_triggered_sample_sequencer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import atss_pkg::*;

  localparam int unsigned NUM_CH         = 6;
  localparam int unsigned SEAL_LEN       = 500;
  localparam int unsigned IDLE_PCT       = 37;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned MAX_PRINTED    = 100;
  localparam int          ALT_MIN        = -1000;
  localparam int          ALT_MAX        = 60000;
  localparam int unsigned ALT_IDX_W      = $clog2(NUM_ALT_REGS);

  // Register indexes: the base of the altitude registers and two that decode to nothing.
  localparam logic [CFG_IDX_W-1:0] REG_ALT_BASE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = 4'd9;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 4'd15;

  typedef enum logic [1:0] {
    REQ_TICK,
    REQ_CFG,
    REQ_SETTLE
  } req_kind_e;

  typedef struct {
    req_kind_e               kind;
    logic signed [ALT_W-1:0] alt;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DAT_W-1:0]    data;
  } seq_req_t;

  typedef struct packed {
    logic               pump_on;
    logic               exhaust_open;
    logic [MASK_W-1:0]  solenoid_mask;
    logic [PHASE_W-1:0] reported_phase;
  } valve_state_t;

  // Clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Signals driven into the block, all known from time zero.
  logic                    tick_valid = 1'b0;
  logic signed [ALT_W-1:0] tick_alt   = '0;
  logic                    cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [CFG_DAT_W-1:0]    cfg_data   = '0;
  logic                    res_ready  = 1'b0;

  atss_in_if  tick_if ();
  atss_out_if res_if ();
  atss_cfg_if cfg_if ();

  assign tick_if.valid    = tick_valid;
  assign tick_if.altitude = tick_alt;
  assign cfg_if.valid     = cfg_valid;
  assign cfg_if.index     = cfg_index;
  assign cfg_if.data      = cfg_data;
  assign res_if.ready     = res_ready;

  altitude_triggered_sample_sequencer_core #(
    .NUM_CHANNELS(NUM_CH),
    .SEAL_TICKS  (SEAL_LEN),
    .TIMER_BITS  (TICK_W)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (tick_if),
    .out_o (res_if),
    .cfg_i (cfg_if)
  );

  // Stimulus waiting to be sent and valve states waiting to be seen.
  seq_req_t     pending_reqs[$];
  valve_state_t expected_valves[$];
  int unsigned  ticks_sent;
  int unsigned  fail_count;
  int unsigned  idle_cycles;
  logic         calm;

  // No idling on either side during one stretch of the run.
  assign calm = (ticks_sent >= 700) && (ticks_sent < 900);

  // Shadow copy of the sequencer state and its registers.
  phase_e                  chan_phase [NUM_CH];
  logic [TICK_W-1:0]       chan_timer [NUM_CH];
  logic                    pump_lvl;
  logic                    exhaust_lvl;
  logic [MASK_W-1:0]       solenoid_lvl;
  logic signed [ALT_W-1:0] start_alt [NUM_ALT_REGS];
  logic [TICK_W-1:0]       clean_len;
  logic [TICK_W-1:0]       sample_len;

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  // Moves every channel by one tick at the given altitude.
  task automatic advance_tick(input logic signed [ALT_W-1:0] alt, output valve_state_t res);
    phase_e            ph;
    logic [TICK_W-1:0] t;
    phase_e            shown;
    shown = PH_DONE;
    for (int i = 0; i < NUM_CH; i++) begin
      ph = chan_phase[i];
      t  = chan_timer[i];
      // Timers of running channels count up whether or not they are served.
      if ((ph == PH_CLEAN || ph == PH_SEAL || ph == PH_ACTIVE) && t != '1) begin
        t = t + 1'b1;
      end
      if (start_alt[i] < alt && ph != PH_DONE) begin
        case (ph)
          PH_IDLE: begin
            exhaust_lvl = 1'b1;
            pump_lvl    = 1'b1;
            t           = '0;
            ph          = PH_CLEAN;
          end
          PH_CLEAN: begin
            if (t >= clean_len) begin
              exhaust_lvl = 1'b0;
              t           = '0;
              ph          = PH_SEAL;
            end
          end
          PH_SEAL: begin
            if (t >= TICK_W'(SEAL_LEN)) begin
              solenoid_lvl[i] = 1'b1;
              t               = '0;
              ph              = PH_ACTIVE;
            end
          end
          PH_ACTIVE: begin
            if (t >= sample_len) begin
              solenoid_lvl[i] = 1'b0;
              pump_lvl        = 1'b0;
              ph              = PH_DONE;
            end
          end
          default: ;
        endcase
      end
      chan_phase[i] = ph;
      chan_timer[i] = t;
      if (ph == PH_CLEAN || ph == PH_SEAL || ph == PH_ACTIVE) begin
        shown = ph;
      end
    end
    res = '{pump_on: pump_lvl, exhaust_open: exhaust_lvl, solenoid_mask: solenoid_lvl,
            reported_phase: shown};
  endtask

  task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DAT_W-1:0] data);
    if (idx < CFG_IDX_W'(NUM_ALT_REGS)) begin
      start_alt[idx[ALT_IDX_W-1:0]] = data[ALT_W-1:0];
    end else if (idx == REG_CLEAN_TICKS) begin
      clean_len = data;
    end else if (idx == REG_SAMPLE_TICKS) begin
      sample_len = data;
    end
  endtask

  // Driver: sends tick and register requests from the pending queue.
  always @(posedge clk_i or negedge rst_ni) begin
    valve_state_t            predicted;
    seq_req_t                head;
    logic                    nxt_tv;
    logic                    nxt_cv;
    logic signed [ALT_W-1:0] nxt_alt;
    logic [CFG_IDX_W-1:0]    nxt_idx;
    logic [CFG_DAT_W-1:0]    nxt_data;
    if (!rst_ni) begin
      tick_valid   <= 1'b0;
      cfg_valid    <= 1'b0;
      ticks_sent   = 0;
      pump_lvl     = 1'b0;
      exhaust_lvl  = 1'b0;
      solenoid_lvl = '0;
      clean_len    = TICK_W'(CLEAN_RESET);
      sample_len   = TICK_W'(SAMPLE_RESET);
      for (int i = 0; i < NUM_CH; i++) begin
        chan_phase[i] = PH_IDLE;
        chan_timer[i] = '0;
      end
      for (int i = 0; i < NUM_ALT_REGS; i++) begin
        start_alt[i] = ALT_W'(ALT_STEP_M * (i + 1));
      end
    end else begin
      nxt_tv   = tick_valid;
      nxt_cv   = cfg_valid;
      nxt_alt  = tick_alt;
      nxt_idx  = cfg_index;
      nxt_data = cfg_data;
      // Retire the requests taken at this edge.
      if (tick_valid && tick_if.ready) begin
        advance_tick(tick_alt, predicted);
        expected_valves.push_back(predicted);
        ticks_sent++;
        nxt_tv = 1'b0;
      end
      if (cfg_valid && cfg_if.ready) begin
        apply_reg_write(cfg_index, cfg_data);
        nxt_cv = 1'b0;
      end
      // Offer the next request, with random gaps between ticks.
      if (!nxt_tv && !nxt_cv && pending_reqs.size() > 0) begin
        head = pending_reqs[0];
        case (head.kind)
          REQ_TICK: begin
            if (calm || $urandom_range(99, 0) >= IDLE_PCT) begin
              nxt_tv  = 1'b1;
              nxt_alt = head.alt;
              void'(pending_reqs.pop_front());
            end
          end
          REQ_CFG: begin
            nxt_cv   = 1'b1;
            nxt_idx  = head.idx;
            nxt_data = head.data;
            void'(pending_reqs.pop_front());
          end
          REQ_SETTLE: begin
            if (expected_valves.size() == 0) begin
              void'(pending_reqs.pop_front());
            end
          end
          default: ;
        endcase
      end
      tick_valid <= nxt_tv;
      tick_alt   <= nxt_alt;
      cfg_valid  <= nxt_cv;
      cfg_index  <= nxt_idx;
      cfg_data   <= nxt_data;
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    valve_state_t got;
    valve_state_t want;
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else begin
      if (res_if.valid && res_ready) begin
        got = {res_if.pump_on, res_if.exhaust_open, res_if.solenoid_mask,
               res_if.reported_phase};
        if (expected_valves.size() == 0) begin
          report_mismatch($sformatf("result %h with no tick pending", got));
        end else begin
          want = expected_valves.pop_front();
          if (got.pump_on !== want.pump_on) begin
            report_mismatch($sformatf("pump_on %b, want %b", got.pump_on, want.pump_on));
          end
          if (got.exhaust_open !== want.exhaust_open) begin
            report_mismatch($sformatf("exhaust_open %b, want %b",
                                      got.exhaust_open, want.exhaust_open));
          end
          if (got.solenoid_mask !== want.solenoid_mask) begin
            report_mismatch($sformatf("solenoid_mask %b, want %b",
                                      got.solenoid_mask, want.solenoid_mask));
          end
          if (got.reported_phase !== want.reported_phase) begin
            report_mismatch($sformatf("reported_phase %0d, want %0d",
                                      got.reported_phase, want.reported_phase));
          end
        end
      end
      res_ready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
    end
  end

  // Watchdog: ends the run when no request moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((tick_valid && tick_if.ready) || (cfg_valid && cfg_if.ready) ||
          (res_if.valid && res_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no request accepted for %0d cycles", idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  task automatic queue_tick(input int meters);
    pending_reqs.push_back('{kind: REQ_TICK, alt: ALT_W'(meters), idx: '0, data: '0});
  endtask

  task automatic queue_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DAT_W-1:0] data);
    pending_reqs.push_back('{kind: REQ_CFG, alt: '0, idx: idx, data: data});
  endtask

  // Altitude writes carry random junk above the 17 decoded bits.
  task automatic queue_alt_write(input int ch, input int meters);
    queue_reg_write(REG_ALT_BASE + CFG_IDX_W'(ch),
                    {(CFG_DAT_W - ALT_W)'($urandom), ALT_W'(meters)});
  endtask

  task automatic queue_settle();
    pending_reqs.push_back('{kind: REQ_SETTLE, alt: '0, idx: '0, data: '0});
  endtask

  // Mostly climbing above the given floor, sometimes anywhere in range.
  function automatic int pick_altitude(input int floor, input int top_pct);
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < top_pct) begin
      return ALT_MAX;
    end else if (roll < 75) begin
      return $urandom_range(ALT_MAX - 1, floor);
    end
    return int'($urandom_range(ALT_MAX - ALT_MIN, 0)) + ALT_MIN;
  endfunction

  initial begin
    int floor;

    // Opening settings: two channels armed, four held back at the top altitude.
    queue_alt_write(0, 1000);
    queue_alt_write(1, ALT_MIN);
    for (int c = 2; c < NUM_CH; c++) begin
      queue_alt_write(c, ALT_MAX);
    end
    queue_reg_write(REG_CLEAN_TICKS, '0);
    queue_reg_write(REG_SAMPLE_TICKS, '1);

    // Directed ticks: thresholds met exactly, just passed, and dropped below.
    queue_tick(ALT_MIN);
    queue_tick(ALT_MIN + 1);
    queue_tick(1000);
    queue_tick(1001);
    queue_tick(999);
    queue_tick(1001);
    queue_tick(ALT_MAX);
    queue_tick(ALT_MAX - 1);
    queue_tick(0);
    queue_tick(-1);
    queue_tick(32768);
    queue_tick(32767);
    queue_tick(1001);
    queue_settle();

    // Channels 2 and 3 join; the active length is too long to end during this stretch.
    queue_reg_write(REG_UNUSED_LOW, CFG_DAT_W'($urandom));
    queue_reg_write(REG_UNUSED_TOP, CFG_DAT_W'($urandom));
    queue_alt_write(2, $urandom_range(3000, 0));
    queue_alt_write(3, $urandom_range(3000, 0));
    queue_reg_write(REG_CLEAN_TICKS, CFG_DAT_W'($urandom_range(30, 0)));
    for (int n = 0; n < 520; n++) begin
      // Hold off once mid-phase until every result is back.
      if (n == 260) begin
        queue_settle();
      end
      queue_tick(pick_altitude(3001, 0));
    end
    queue_settle();

    // Short active length ends the stuck channels; cleaning now cannot end in this stretch.
    floor = $urandom_range(8000, 1000);
    queue_reg_write(REG_SAMPLE_TICKS, CFG_DAT_W'($urandom_range(50, 0)));
    queue_reg_write(REG_CLEAN_TICKS, '1);
    queue_alt_write(4, floor);
    queue_alt_write(5, ALT_MAX - 1);
    for (int n = 0; n < 100; n++) begin
      queue_tick(pick_altitude(floor + 1, 10));
    end
    queue_settle();

    // Release cleaning and let the last channels run to completion.
    queue_reg_write(REG_CLEAN_TICKS, CFG_DAT_W'($urandom_range(10, 1)));
    queue_reg_write(REG_SAMPLE_TICKS, '0);
    queue_alt_write(5, ALT_MIN);
    queue_alt_write(0, ALT_MAX);
    for (int n = 0; n < 510; n++) begin
      queue_tick(pick_altitude(floor + 1, 5));
    end

    // Hold reset, then release it away from the rising edge.
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for the stimulus to drain and every result to come back.
    while (pending_reqs.size() != 0 || tick_valid || cfg_valid ||
           expected_valves.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
